// ===== hw/rtl/efwd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efwd_pkg
// Shared constants and a saturating add for the earliest-finish work dispatcher.
// ----------------------------------------------------------------------------
package efwd_pkg;

    localparam int MAX_WORKERS      = 4;
    localparam int FACTOR_FRAC_BITS = 12;
    localparam int WIDX_W           = 2;
    localparam int OPS_W            = 48;
    localparam int TIME_W           = 32;
    localparam int RATE_W           = 32;
    localparam int FACT_W           = 16;
    localparam int SETUP_W          = 48;
    localparam int CFG_IDX_W        = 3;
    // Dividend register width: ops, or a value of up to 48 bits shifted by the fraction bits.
    localparam int DIVD_W           = 64;
    localparam int DCNT_W           = 7;

    localparam logic [TIME_W-1:0] SAT = {TIME_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 3'd4;

    localparam logic CMD_DISPATCH = 1'b0;
    localparam logic CMD_CLEAR    = 1'b1;

    localparam logic POL_FINISH = 1'b0;
    localparam logic POL_LOAD   = 1'b1;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? SAT : s[TIME_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/earliest_finish_work_dispatcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_finish_work_dispatcher
// Greedy list scheduler: assigns each work item to the worker that finishes it
// earliest (or by capability-weighted load) using one bit-serial divider.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | valid, stall, command, work_ops      | in
//  result  | out_valid, out_stall, worker_index.. | out
//  config  | cfg_valid, cfg_ready, cfg_index, ... | in
//
// One item at a time. A dispatch runs up to three restoring divisions per
// worker (ops/rate, base*4096/factor, exec*4096/factor) plus one for the load
// update, each one quotient bit per cycle. Policy 0 needs only the first two
// per worker and no load update. Disabled workers are skipped in the scan
// state. A clear is done in the cycle of its transfer. The result waits in
// an output register and holds stall high; the next item is accepted the
// cycle after it has been taken. Asynchronous reset.
module earliest_finish_work_dispatcher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid,
    output logic                                stall,
    input  logic                                command,
    input  logic [efwd_pkg::OPS_W-1:0]          work_ops,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [efwd_pkg::WIDX_W-1:0]         worker_index,
    output logic                                assigned,
    output logic [efwd_pkg::TIME_W-1:0]         exec_time_ms,
    output logic [efwd_pkg::TIME_W-1:0]         worker_busy_ms,
    output logic [efwd_pkg::TIME_W-1:0]         makespan_ms,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [efwd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [efwd_pkg::SETUP_W-1:0]        cfg_data
);

    localparam int NW = efwd_pkg::MAX_WORKERS;
    localparam int TW = efwd_pkg::TIME_W;
    localparam int FB = efwd_pkg::FACTOR_FRAC_BITS;
    localparam int DW = efwd_pkg::DIVD_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DIV_BASE, S_DIV_EXEC, S_DIV_KEY, S_CMP,
        S_UPDATE, S_DIV_LOAD, S_SPAN, S_DONE
    } state_t;

    state_t                          state_reg;
    logic [efwd_pkg::SETUP_W-1:0]    setup_reg [efwd_pkg::MAX_WORKERS];
    logic                            policy_reg;
    logic [TW-1:0]                   busy_reg [efwd_pkg::MAX_WORKERS];
    logic [TW-1:0]                   load_reg [efwd_pkg::MAX_WORKERS];
    logic [efwd_pkg::OPS_W-1:0]      ops_reg;
    logic [efwd_pkg::WIDX_W-1:0]     w_reg;
    logic [efwd_pkg::WIDX_W-1:0]     best_reg;
    logic                            found_reg;
    logic [TW-1:0]                   best_key_reg;
    logic [TW-1:0]                   best_exec_reg;
    logic [TW-1:0]                   exec_reg;
    logic [TW-1:0]                   key_reg;
    logic [TW-1:0]                   span_reg;

    // restoring divider: remainder, dividend shift register, quotient
    logic [DW-1:0]                   divd_reg;
    logic [DW-1:0]                   quo_reg;
    logic [efwd_pkg::RATE_W:0]       rem_reg;
    logic [efwd_pkg::RATE_W-1:0]     dsor_reg;
    logic [efwd_pkg::DCNT_W-1:0]     cnt_reg;

    logic [efwd_pkg::RATE_W:0]       rem_sh;
    logic [efwd_pkg::RATE_W:0]       rem_sub;
    logic                            q_bit;
    logic                            div_last;

    logic [efwd_pkg::RATE_W-1:0]     rate_w;
    logic [efwd_pkg::FACT_W-1:0]     fact_w;
    logic                            en_w;
    logic [efwd_pkg::FACT_W-1:0]     fact_best;
    logic [TW-1:0]                   new_busy;

    assign rate_w = setup_reg[w_reg][efwd_pkg::SETUP_W-1:efwd_pkg::FACT_W];
    assign fact_w = setup_reg[w_reg][efwd_pkg::FACT_W-1:0];
    assign en_w   = (rate_w != '0) && (fact_w != '0);
    assign fact_best = setup_reg[best_reg][efwd_pkg::FACT_W-1:0];
    assign new_busy  = efwd_pkg::sat_add(busy_reg[best_reg], best_exec_reg);

    assign rem_sh  = {rem_reg[efwd_pkg::RATE_W-1:0], divd_reg[DW-1]};
    assign rem_sub = rem_sh - {1'b0, dsor_reg};
    assign q_bit   = ~rem_sub[efwd_pkg::RATE_W];
    assign div_last = (cnt_reg == '0);

    assign stall     = (state_reg != S_IDLE) || out_valid;
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= efwd_pkg::POL_LOAD;
            out_valid     <= 1'b0;
            ops_reg       <= '0;
            w_reg         <= '0;
            best_reg      <= '0;
            found_reg     <= 1'b0;
            best_key_reg  <= '0;
            best_exec_reg <= '0;
            exec_reg      <= '0;
            key_reg       <= '0;
            span_reg      <= '0;
            divd_reg      <= '0;
            quo_reg       <= '0;
            rem_reg       <= '0;
            dsor_reg      <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < NW; i++)
            begin
                setup_reg[i] <= '0;
                busy_reg[i]  <= '0;
                load_reg[i]  <= '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
                out_valid <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index < efwd_pkg::CFG_IDX_W'(NW))
                    setup_reg[cfg_index[efwd_pkg::WIDX_W-1:0]] <= cfg_data;
                else if (cfg_index == efwd_pkg::REG_POLICY)
                    policy_reg <= cfg_data[0];
            end

            // divider step, shared by every division state; the last step is
            // taken by the state that consumes the quotient
            if ((state_reg == S_DIV_BASE || state_reg == S_DIV_EXEC ||
                 state_reg == S_DIV_KEY || state_reg == S_DIV_LOAD) && !div_last)
            begin
                rem_reg  <= q_bit ? rem_sub : rem_sh;
                divd_reg <= {divd_reg[DW-2:0], 1'b0};
                quo_reg  <= {quo_reg[DW-2:0], q_bit};
                cnt_reg  <= cnt_reg - 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (valid && !out_valid)
                    begin
                        if (command == efwd_pkg::CMD_CLEAR)
                        begin
                            for (int i = 0; i < NW; i++)
                            begin
                                busy_reg[i] <= '0;
                                load_reg[i] <= '0;
                            end
                        end
                        else
                        begin
                            ops_reg   <= work_ops;
                            w_reg     <= '0;
                            found_reg <= 1'b0;
                            best_reg  <= '0;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (en_w)
                    begin
                        divd_reg  <= DW'(ops_reg) << (DW - efwd_pkg::OPS_W);
                        dsor_reg  <= rate_w;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= efwd_pkg::DCNT_W'(efwd_pkg::OPS_W - 1);
                        state_reg <= S_DIV_BASE;
                    end
                    else if (w_reg == efwd_pkg::WIDX_W'(NW - 1))
                        state_reg <= S_UPDATE;
                    else
                        w_reg <= w_reg + 1'b1;
                end
                S_DIV_BASE:
                begin
                    if (div_last)
                    begin
                        // base < 2^48, shifted by FB fits in 64 bits
                        divd_reg  <= DW'({quo_reg[efwd_pkg::OPS_W-2:0], q_bit}) << FB;
                        dsor_reg  <= efwd_pkg::RATE_W'(fact_w);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= efwd_pkg::DCNT_W'(DW - 1);
                        state_reg <= S_DIV_EXEC;
                    end
                end
                S_DIV_EXEC, S_DIV_KEY, S_DIV_LOAD:
                begin
                    if (div_last)
                    begin
                        logic [DW-1:0] q;
                        logic [TW-1:0] qs;
                        q  = {quo_reg[DW-2:0], q_bit};
                        qs = (q[DW-1:TW] != '0) ? efwd_pkg::SAT : q[TW-1:0];
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= efwd_pkg::DCNT_W'(DW - 1);
                        if (state_reg == S_DIV_EXEC)
                        begin
                            exec_reg <= qs;
                            if (policy_reg == efwd_pkg::POL_LOAD)
                            begin
                                divd_reg  <= DW'(qs) << FB;
                                state_reg <= S_DIV_KEY;
                            end
                            else
                            begin
                                key_reg   <= efwd_pkg::sat_add(busy_reg[w_reg], qs);
                                state_reg <= S_CMP;
                            end
                        end
                        else if (state_reg == S_DIV_KEY)
                        begin
                            key_reg   <= efwd_pkg::sat_add(load_reg[w_reg], qs);
                            state_reg <= S_CMP;
                        end
                        else
                        begin
                            load_reg[best_reg] <= qs;
                            state_reg          <= S_SPAN;
                        end
                    end
                end
                S_CMP:
                begin
                    if (!found_reg || key_reg < best_key_reg)
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= w_reg;
                        best_key_reg  <= key_reg;
                        best_exec_reg <= exec_reg;
                    end
                    if (w_reg == efwd_pkg::WIDX_W'(NW - 1))
                        state_reg <= S_UPDATE;
                    else
                    begin
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_UPDATE:
                begin
                    if (found_reg)
                    begin
                        busy_reg[best_reg] <= new_busy;
                        if (policy_reg == efwd_pkg::POL_LOAD)
                        begin
                            divd_reg  <= DW'(new_busy) << FB;
                            dsor_reg  <= efwd_pkg::RATE_W'(fact_best);
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            cnt_reg   <= efwd_pkg::DCNT_W'(DW - 1);
                            state_reg <= S_DIV_LOAD;
                        end
                        else
                            state_reg <= S_SPAN;
                    end
                    else
                        state_reg <= S_SPAN;
                end
                S_SPAN:
                begin
                    logic [TW-1:0] m;
                    m = '0;
                    for (int i = 0; i < NW; i++)
                        if (busy_reg[i] > m)
                            m = busy_reg[i];
                    span_reg  <= m;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign worker_index   = found_reg ? best_reg : '0;
    assign assigned       = found_reg;
    assign exec_time_ms   = found_reg ? best_exec_reg : '0;
    assign worker_busy_ms = found_reg ? busy_reg[best_reg] : '0;
    assign makespan_ms    = span_reg;

endmodule

// ===== hw/rtl/efwd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efwd_checker
// Port-level checks for the earliest-finish work dispatcher.
// ----------------------------------------------------------------------------
module efwd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            valid,
    input logic                            stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic                            assigned,
    input logic [efwd_pkg::WIDX_W-1:0]     worker_index,
    input logic [efwd_pkg::TIME_W-1:0]     exec_time_ms,
    input logic [efwd_pkg::TIME_W-1:0]     worker_busy_ms,
    input logic [efwd_pkg::TIME_W-1:0]     makespan_ms,
    input logic                            cfg_ready
);

    // a held result stays valid and keeps its busy time
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(worker_busy_ms))
        else $error("result changed while stalled");

    a_unassigned_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !assigned |-> exec_time_ms == '0 && worker_index == '0)
        else $error("unassigned result not zero");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && assigned |-> worker_busy_ms <= makespan_ms)
        else $error("busy time above makespan");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !stall && !out_valid)
        else $error("config taken while busy");

endmodule

bind earliest_finish_work_dispatcher efwd_checker u_efwd_checker (.*);
